>>> rtl/bio_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bio_pkg
// Shared widths, types and the 3x3 window functions of the outline block.
// ----------------------------------------------------------------------------
package bio_pkg;

  localparam int PIX_W = 16;
  localparam int CFG_W = 7;

  typedef logic [PIX_W-1:0] word_t;

  // window rows: 0 above, 1 middle, 2 incoming; columns: 0 left, 1 centre, 2 right
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    word_t outline_pixels;
    logic  row_end;
    logic  last;
  } res_t;

  function automatic win_t win_shift(win_t w, word_t a, word_t m, word_t b);
    win_t nw;
    nw    = w;
    nw[0] = w[1];
    nw[1] = w[2];
    nw[2] = a;
    nw[3] = w[4];
    nw[4] = w[5];
    nw[5] = m;
    nw[6] = w[7];
    nw[7] = w[8];
    nw[8] = b;
    return nw;
  endfunction

  function automatic logic [PIX_W+1:0] span_of(word_t l, word_t c, word_t r);
    return {l[0], c, r[PIX_W-1]};
  endfunction

  function automatic word_t outline_word(win_t w);
    logic [PIX_W+1:0] a;
    logic [PIX_W+1:0] m;
    logic [PIX_W+1:0] b;
    logic [PIX_W+1:0] nb;
    a  = span_of(w[0], w[1], w[2]);
    m  = span_of(w[3], w[4], w[5]);
    b  = span_of(w[6], w[7], w[8]);
    nb = a | (a << 1) | (a >> 1) | b | (b << 1) | (b >> 1) | (m << 1) | (m >> 1);
    return nb[PIX_W:1] & ~w[4];
  endfunction

endpackage
`default_nettype wire

>>> rtl/binary_image_outline.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_image_outline
// 8-neighbour outline of a 1-bit raster image streamed as 16-pixel words.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle unless the output queue lacks room;
// after the first row of an image, the first word of a row yields no result
// beat and the last yields two, so a row of N words gives N beats. Both line
// buffers share one RAM read and one write per word.
// Reset clears counters, window and output queue; line buffers keep contents.
// ----------------------------------------------------------------------------
module binary_image_outline #(
  parameter int MAX_WORDS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [bio_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [bio_pkg::PIX_W-1:0] pixels,
  input  wire logic                      image_start,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [bio_pkg::PIX_W-1:0] outline_pixels,
  output logic                           row_end,
  output logic                           last
);
  import bio_pkg::*;

  localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LIM_W  = $clog2(MAX_WORDS + 1);
  localparam int CMP_W  = (LIM_W > CFG_W) ? LIM_W : CFG_W;

  logic [CFG_W-1:0]  line_words;
  logic [ADDR_W-1:0] column_count;
  logic [1:0]        rows_seen;

  logic              s1_valid;
  word_t             s1_pixels;
  logic [ADDR_W-1:0] s1_col;
  logic              s1_last_col;
  logic [1:0]        s1_rows;
  logic              fwd;
  logic [2*PIX_W-1:0] fwd_data;
  logic [2*PIX_W-1:0] ram_q;

  win_t              win;
  res_t              q [2];
  res_t              q_next [2];
  logic [1:0]        count;
  logic [1:0]        count_next;

  logic              in_fire;
  logic              s1_fire;
  logic              pop;

  logic [CMP_W-1:0]  len;
  logic [CMP_W-1:0]  col_ext;
  logic [ADDR_W-1:0] cnt_cur;
  logic [ADDR_W-1:0] col;
  logic              col_last;
  logic [1:0]        rs_cur;

  logic [2*PIX_W-1:0] rd;
  logic [2*PIX_W-1:0] wr_data;
  word_t             above;
  word_t             middle;
  win_t              base;
  win_t              w1;
  win_t              w2;
  logic              has_mid;
  logic              has_end;
  logic [1:0]        n_push;
  logic [1:0]        count_pop;
  res_t              res0;
  res_t              res1;

  // input side: row position of the arriving word
  always_comb begin
    if (line_words == '0) begin
      len = CMP_W'(1);
    end else if (CMP_W'(line_words) > CMP_W'(MAX_WORDS)) begin
      len = CMP_W'(MAX_WORDS);
    end else begin
      len = CMP_W'(line_words);
    end
    cnt_cur  = image_start ? '0 : column_count;
    rs_cur   = image_start ? 2'd0 : rows_seen;
    col_ext  = (CMP_W'(cnt_cur) >= len) ? len - CMP_W'(1) : CMP_W'(cnt_cur);
    col      = col_ext[ADDR_W-1:0];
    col_last = (col_ext == len - CMP_W'(1));
  end

  // processing stage
  always_comb begin
    rd      = fwd ? fwd_data : ram_q;
    above   = (s1_rows >= 2'd2) ? rd[2*PIX_W-1:PIX_W] : '0;
    middle  = (s1_rows != 2'd0) ? rd[PIX_W-1:0] : '0;
    wr_data = {rd[PIX_W-1:0], s1_pixels};
    base    = (s1_col == '0) ? '0 : win;
    w1      = win_shift(base, above, middle, s1_pixels);
    w2      = win_shift(w1, '0, '0, '0);
    has_mid = (s1_rows != 2'd0) && (s1_col != '0);
    has_end = (s1_rows != 2'd0) && s1_last_col;
    n_push  = {1'b0, has_mid} + {1'b0, has_end};
    res1    = '{outline_pixels: outline_word(w2), row_end: 1'b1, last: 1'b1};
    if (has_mid) begin
      res0 = '{outline_pixels: outline_word(w1), row_end: 1'b0, last: !has_end};
    end else begin
      res0 = res1;
    end
  end

  assign pop       = out_valid && out_ready;
  assign count_pop = count - {1'b0, pop};
  assign s1_fire   = s1_valid && ({1'b0, count_pop} + {1'b0, n_push} <= 3'd2);
  assign in_ready  = !s1_valid || s1_fire;
  assign in_fire   = in_valid && in_ready;

  // output queue, two entries
  always_comb begin
    q_next     = q;
    count_next = count_pop;
    if (pop) begin
      q_next[0] = q[1];
    end
    if (s1_fire && n_push != 2'd0) begin
      q_next[count_pop[0]] = res0;
      if (n_push == 2'd2) begin
        q_next[1] = res1;
      end
      count_next = count_pop + n_push;
    end
  end

  assign out_valid      = (count != 2'd0);
  assign outline_pixels = q[0].outline_pixels;
  assign row_end        = q[0].row_end;
  assign last           = q[0].last;

  bio_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WORDS)
  ) u_lines (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (col),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_words   <= CFG_W'(1);
      column_count <= '0;
      rows_seen    <= 2'd0;
      s1_valid     <= 1'b0;
      count        <= 2'd0;
      win          <= '0;
    end else begin
      if (cfg_we) begin
        line_words <= cfg_wdata;
      end
      if (in_fire) begin
        column_count <= col_last ? '0 : col + ADDR_W'(1);
        rows_seen    <= (col_last && rs_cur != 2'd2) ? rs_cur + 2'd1 : rs_cur;
        s1_valid     <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        win <= s1_last_col ? w2 : w1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (in_fire) begin
      s1_pixels   <= pixels;
      s1_col      <= col;
      s1_last_col <= col_last;
      s1_rows     <= rs_cur;
      fwd         <= s1_fire && (s1_col == col);
      fwd_data    <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bio_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bio_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bio_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bio_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bio_checker
// Port-level checks of the outline block, bound to the top level.
// ----------------------------------------------------------------------------
module bio_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] outline_pixels,
  input wire logic        row_end,
  input wire logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outline_pixels))
    else $error("stalled output beat changed");

  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end |-> last)
    else $error("row end beat not last of its word");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("second beat of a word missing");

endmodule

bind binary_image_outline bio_checker u_bio_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .outline_pixels (outline_pixels),
  .row_end        (row_end),
  .last           (last)
);
`default_nettype wire
